@@ rtl/cdt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants of the cube-map direction to texel block.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int DIR_W     = 16;
    localparam int MAG_W     = 17;
    localparam int FACE_W    = 3;
    localparam int TEX_W     = 10;
    localparam int OFF_W     = 27;
    localparam int RB_W      = 28;
    localparam int CFG_W     = 28;
    localparam int CFG_IDX_W = 2;
    localparam int FW_W      = 11;
    localparam int MIP_W     = 4;
    localparam int TEXEL_SH  = 3;

    localparam int DEF_MAX_FACE_SIZE  = 1024;
    localparam int DEF_MAX_MIP_LEVELS = 11;

    localparam logic [FW_W-1:0]  RST_FACE_W  = FW_W'(256);
    localparam logic [FW_W-1:0]  RST_FACE_H  = FW_W'(256);
    localparam logic [MIP_W-1:0] RST_MIPS    = MIP_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_FACE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIP_LEVELS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIANCE_BYTES = 2'd3;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    // classified request: numerators already offset by the major magnitude
    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic [MAG_W-1:0]  su;
        logic [MAG_W-1:0]  sv;
        logic [MAG_W-1:0]  mag;
    } item_t;

    typedef struct packed {
        logic              in_range;
        logic [OFF_W-1:0]  offset;
        logic [TEX_W-1:0]  ty;
        logic [TEX_W-1:0]  tx;
        logic [FACE_W-1:0] face;
    } result_t;

    typedef struct packed {
        logic             busy;
        logic [OFF_W-1:0] stride;
    } stride_stat_t;

endpackage
`default_nettype wire

@@ rtl/cdt_stride.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_stride
// Face stride unit: sums size*size*8 over the mip chain, one level a cycle.
// ----------------------------------------------------------------------------
module cdt_stride #(
    parameter int SZW = 11,
    parameter int MLW = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                restart,
    input  wire logic [SZW-1:0]      w_eff,
    input  wire logic [MLW-1:0]      levels,
    output cdt_pkg::stride_stat_t    stat
);

    typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_DONE} state_t;

    state_t                     state_reg;
    logic [SZW-1:0]             size_reg;
    logic [MLW-1:0]             cnt_reg;
    logic [cdt_pkg::OFF_W-1:0]  acc_reg;
    logic [2*SZW-1:0]           sq;
    logic [cdt_pkg::OFF_W-1:0]  acc_next;
    logic [SZW-1:0]             size_next;

    assign sq        = size_reg * size_reg;
    assign acc_next  = acc_reg + cdt_pkg::OFF_W'({sq, 3'b000});
    assign size_next = (size_reg[SZW-1:1] == '0) ? SZW'(1) : (size_reg >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            size_reg  <= '0;
        end else if (restart) begin
            state_reg <= ST_LOAD;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    size_reg  <= w_eff;
                    cnt_reg   <= '0;
                    acc_reg   <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    acc_reg  <= acc_next;
                    size_reg <= size_next;
                    cnt_reg  <= cnt_reg + MLW'(1);
                    if (cnt_reg == levels - MLW'(1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    state_reg <= ST_DONE;
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign stat.busy   = (state_reg != ST_DONE);
    assign stat.stride = acc_reg;

endmodule
`default_nettype wire

@@ rtl/cdt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_front
// Front end: takes a direction, picks the major axis and face, registers it.
// ----------------------------------------------------------------------------
module cdt_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        hold,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [cdt_pkg::DIR_W-1:0]   dir_x,
    input  wire logic [cdt_pkg::DIR_W-1:0]   dir_y,
    input  wire logic [cdt_pkg::DIR_W-1:0]   dir_z,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output cdt_pkg::item_t                   out_item
);

    localparam int SW = cdt_pkg::MAG_W + 1;

    logic                   vld_reg;
    cdt_pkg::item_t         item_reg;
    cdt_pkg::item_t         item_next;
    logic signed [SW-1:0]   sx, sy, sz, nu, nv;
    logic [SW-1:0]          ax, ay, az, m, su, sv;
    logic                   take;

    always_comb begin
        sx = SW'(signed'(dir_x));
        sy = SW'(signed'(dir_y));
        sz = SW'(signed'(dir_z));
        ax = sx[SW-1] ? -sx : sx;
        ay = sy[SW-1] ? -sy : sy;
        az = sz[SW-1] ? -sz : sz;
        if (ax >= ay && ax >= az) begin
            m = ax;
            if (!sx[SW-1]) begin
                item_next.face = cdt_pkg::FACE_POS_X; nu = -sz; nv = -sy;
            end else begin
                item_next.face = cdt_pkg::FACE_NEG_X; nu = sz;  nv = -sy;
            end
        end else if (ay >= az) begin
            m = ay;
            if (!sy[SW-1]) begin
                item_next.face = cdt_pkg::FACE_POS_Y; nu = sx; nv = sz;
            end else begin
                item_next.face = cdt_pkg::FACE_NEG_Y; nu = sx; nv = -sz;
            end
        end else begin
            m = az;
            if (!sz[SW-1]) begin
                item_next.face = cdt_pkg::FACE_POS_Z; nu = sx;  nv = -sy;
            end else begin
                item_next.face = cdt_pkg::FACE_NEG_Z; nu = -sx; nv = -sy;
            end
        end
        su = nu + m;
        sv = nv + m;
        item_next.su  = su[cdt_pkg::MAG_W-1:0];
        item_next.sv  = sv[cdt_pkg::MAG_W-1:0];
        item_next.mag = m[cdt_pkg::MAG_W-1:0];
        // zero vector: +z, numerator 1 over divisor 2 gives size/2
        if (m == '0) begin
            item_next.face = cdt_pkg::FACE_POS_Z;
            item_next.su   = cdt_pkg::MAG_W'(1);
            item_next.sv   = cdt_pkg::MAG_W'(1);
            item_next.mag  = cdt_pkg::MAG_W'(1);
        end
    end

    assign in_ready  = (!vld_reg || out_ready) && !hold;
    assign take      = in_valid && in_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (take) begin
            vld_reg <= 1'b1;
        end else if (out_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/cdt_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_queue
// Short request queue between front and back end.
// ----------------------------------------------------------------------------
module cdt_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire cdt_pkg::item_t  wr_item,
    output logic                 rd_valid,
    input  wire logic            rd_pop,
    output cdt_pkg::item_t       rd_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cdt_pkg::item_t  mem [0:DEPTH-1];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [CW-1:0]   cnt_reg;
    logic            push, pop;

    assign wr_ready = (cnt_reg != CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_item  = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            end
            if (pop) begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/cdt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cdt_back
// Back end: scales numerators, divides one quotient bit a stage for u and v,
// clamps, forms the byte offset and range flag.
// ----------------------------------------------------------------------------
module cdt_back #(
    parameter int SZW = 11
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_pop,
    input  wire cdt_pkg::item_t              in_item,
    input  wire logic [SZW-1:0]              w_eff,
    input  wire logic [SZW-1:0]              h_eff,
    input  wire logic [cdt_pkg::OFF_W-1:0]   stride,
    input  wire logic [cdt_pkg::RB_W-1:0]    radiance_bytes,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output cdt_pkg::result_t                 out_res
);

    localparam int QW = SZW;
    localparam int DW = cdt_pkg::MAG_W;
    localparam int NW = cdt_pkg::MAG_W + SZW;
    localparam int OW = cdt_pkg::OFF_W;
    localparam int FW = cdt_pkg::FACE_W;

    logic en;

    logic           vld_reg  [0:QW];
    logic [NW-1:0]  ru_reg   [0:QW];
    logic [NW-1:0]  rv_reg   [0:QW];
    logic [QW-1:0]  qu_reg   [0:QW];
    logic [QW-1:0]  qv_reg   [0:QW];
    logic [DW-1:0]  d_reg    [0:QW];
    logic [FW-1:0]  face_reg [0:QW];

    logic              a_vld_reg, b_vld_reg, c_vld_reg;
    logic [QW-1:0]     a_tx_reg, a_ty_reg;
    logic [2*QW-1:0]   a_row_reg;
    logic [OW-1:0]     a_fs_reg, b_off_reg;
    logic [FW-1:0]     a_face_reg, b_face_reg;
    logic [cdt_pkg::TEX_W-1:0] b_tx_reg, b_ty_reg;
    cdt_pkg::result_t  res_reg;
    logic [QW-1:0]     lim_x, lim_y, tx_c, ty_c;

    assign en        = !c_vld_reg || out_ready;
    assign in_pop    = en && in_valid;
    assign out_valid = c_vld_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ru_reg[0]   <= NW'(in_item.su) * NW'(w_eff);
            rv_reg[0]   <= NW'(in_item.sv) * NW'(h_eff);
            qu_reg[0]   <= '0;
            qv_reg[0]   <= '0;
            d_reg[0]    <= DW'({in_item.mag, 1'b0});
            face_reg[0] <= in_item.face;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int SH = QW - 1 - i;
        logic [NW-1:0] dsh;
        logic          ge_u, ge_v;

        assign dsh  = NW'(d_reg[i]) << SH;
        assign ge_u = (ru_reg[i] >= dsh);
        assign ge_v = (rv_reg[i] >= dsh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ru_reg[i+1]   <= ge_u ? ru_reg[i] - dsh : ru_reg[i];
                rv_reg[i+1]   <= ge_v ? rv_reg[i] - dsh : rv_reg[i];
                qu_reg[i+1]   <= qu_reg[i] | (QW'(ge_u) << SH);
                qv_reg[i+1]   <= qv_reg[i] | (QW'(ge_v) << SH);
                d_reg[i+1]    <= d_reg[i];
                face_reg[i+1] <= face_reg[i];
            end
        end
    end

    assign lim_x = w_eff - QW'(1);
    assign lim_y = h_eff - QW'(1);
    assign tx_c  = (qu_reg[QW] > lim_x) ? lim_x : qu_reg[QW];
    assign ty_c  = (qv_reg[QW] > lim_y) ? lim_y : qv_reg[QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= vld_reg[QW];
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_tx_reg   <= tx_c;
            a_ty_reg   <= ty_c;
            a_row_reg  <= ty_c * w_eff;
            a_fs_reg   <= OW'(face_reg[QW] * stride);
            a_face_reg <= face_reg[QW];

            b_off_reg  <= a_fs_reg
                          + OW'({(2*QW+1)'(a_row_reg) + (2*QW+1)'(a_tx_reg), 3'b000});
            b_tx_reg   <= cdt_pkg::TEX_W'(a_tx_reg);
            b_ty_reg   <= cdt_pkg::TEX_W'(a_ty_reg);
            b_face_reg <= a_face_reg;

            res_reg.face     <= b_face_reg;
            res_reg.tx       <= b_tx_reg;
            res_reg.ty       <= b_ty_reg;
            res_reg.offset   <= b_off_reg;
            res_reg.in_range <= ((cdt_pkg::RB_W'(b_off_reg) + cdt_pkg::RB_W'(8))
                                 <= radiance_bytes);
        end
    end

endmodule
`default_nettype wire

@@ rtl/cubemap_direction_to_texel.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cubemap_direction_to_texel
// Cube-map face selection and texel byte addressing for a direction vector.
// ----------------------------------------------------------------------------
// Takes one direction per cycle while s_tready is high (three signed Q1.15
// components) and returns its face, mip-zero texel column and row, the byte
// offset of the eight-byte texel in a face-major, mip-chained buffer, and
// whether that texel fits in the radiance buffer. Requests pass through the
// front end, the request queue and the back end, where the u and v divisions
// resolve one quotient bit per pipeline stage. After reset and after each write
// of face_width or mip_levels the face stride is rebuilt one mip level a cycle,
// and s_tready stays low until the rebuild is done.
module cubemap_direction_to_texel #(
    parameter int MAX_FACE_SIZE  = cdt_pkg::DEF_MAX_FACE_SIZE,
    parameter int MAX_MIP_LEVELS = cdt_pkg::DEF_MAX_MIP_LEVELS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // dir_x, dir_y, dir_z
    input  wire logic [47:0]                    s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // face, texel_x, texel_y, byte_offset, in_range, zero pad
    output logic [55:0]                         m_tdata,
    input  wire logic                           cfg_wr_en,
    input  wire logic [cdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cdt_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int SZW = $clog2(MAX_FACE_SIZE + 1);
    localparam int MLW = $clog2(MAX_MIP_LEVELS + 1);

    logic [cdt_pkg::FW_W-1:0]  fw_reg, fh_reg;
    logic [cdt_pkg::MIP_W-1:0] mip_reg;
    logic [cdt_pkg::RB_W-1:0]  rb_reg;
    logic [SZW-1:0]            w_eff, h_eff;
    logic [MLW-1:0]            levels;
    logic                      restart;
    cdt_pkg::stride_stat_t     sstat;
    cdt_pkg::item_t            f_item, q_item;
    cdt_pkg::result_t          res;
    logic                      f_valid, q_ready, q_valid, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg  <= cdt_pkg::RST_FACE_W;
            fh_reg  <= cdt_pkg::RST_FACE_H;
            mip_reg <= cdt_pkg::RST_MIPS;
            rb_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cdt_pkg::REG_FACE_WIDTH:     fw_reg  <= cfg_wdata[cdt_pkg::FW_W-1:0];
                cdt_pkg::REG_FACE_HEIGHT:    fh_reg  <= cfg_wdata[cdt_pkg::FW_W-1:0];
                cdt_pkg::REG_MIP_LEVELS:     mip_reg <= cfg_wdata[cdt_pkg::MIP_W-1:0];
                cdt_pkg::REG_RADIANCE_BYTES: rb_reg  <= cfg_wdata[cdt_pkg::RB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign restart = cfg_wr_en && (cfg_index == cdt_pkg::REG_FACE_WIDTH
                                   || cfg_index == cdt_pkg::REG_MIP_LEVELS);

    always_comb begin
        if (fw_reg == '0) begin
            w_eff = SZW'(1);
        end else if (32'(fw_reg) > MAX_FACE_SIZE) begin
            w_eff = SZW'(MAX_FACE_SIZE);
        end else begin
            w_eff = SZW'(fw_reg);
        end
        if (fh_reg == '0) begin
            h_eff = SZW'(1);
        end else if (32'(fh_reg) > MAX_FACE_SIZE) begin
            h_eff = SZW'(MAX_FACE_SIZE);
        end else begin
            h_eff = SZW'(fh_reg);
        end
        if (mip_reg == '0) begin
            levels = MLW'(1);
        end else if (32'(mip_reg) > MAX_MIP_LEVELS) begin
            levels = MLW'(MAX_MIP_LEVELS);
        end else begin
            levels = MLW'(mip_reg);
        end
    end

    cdt_stride #(.SZW(SZW), .MLW(MLW)) u_stride (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .w_eff   (w_eff),
        .levels  (levels),
        .stat    (sstat)
    );

    cdt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hold      (sstat.busy),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .dir_x     (s_tdata[15:0]),
        .dir_y     (s_tdata[31:16]),
        .dir_z     (s_tdata[47:32]),
        .out_valid (f_valid),
        .out_ready (q_ready),
        .out_item  (f_item)
    );

    cdt_queue #(.DEPTH(4)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (q_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    cdt_back #(.SZW(SZW)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (q_valid),
        .in_pop         (q_pop),
        .in_item        (q_item),
        .w_eff          (w_eff),
        .h_eff          (h_eff),
        .stride         (sstat.stride),
        .radiance_bytes (rb_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_res        (res)
    );

    assign m_tdata = {5'b00000, res.in_range, res.offset, res.ty, res.tx, res.face};

`ifndef SYNTH
    a_hold_while_stride: assert property (@(posedge aclk) disable iff (!aresetn)
        sstat.busy |-> !s_tready)
        else $error("request taken while face stride rebuilds");

    a_face_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= cdt_pkg::FACE_NEG_Z))
        else $error("face code out of range");

    a_range_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[50] ==
            ((cdt_pkg::RB_W'(m_tdata[49:23]) + cdt_pkg::RB_W'(8)) <= rb_reg)))
        else $error("range flag disagrees with offset");

    a_queue_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (f_valid && !q_ready) |=> f_valid)
        else $error("front request dropped while queue full");
`endif

endmodule
`default_nettype wire
